/* sv/quaternion_to_axis_angle_defines.svh */
// Assertion macros for the quaternion to axis-angle block.
// Included by files that carry concurrent checks; expects clk and arst_n in scope.
`ifndef QUATERNION_TO_AXIS_ANGLE_DEFINES_SVH
`define QUATERNION_TO_AXIS_ANGLE_DEFINES_SVH

// Check a condition at every clock edge outside reset.
`define QTA_ASSERT_NOW(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Check that a consequence holds in the cycle after an antecedent.
`define QTA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/qta_pkg.sv */
// Shared constants, widths and the arctangent table of the axis-angle pipeline.
// No dependencies; imported by the interfaces, the top level, qta_cordic, qta_div and the testbench.
`default_nettype none
package qta_pkg;
	localparam int DATA_WIDTH = 16;
	localparam int AW_W       = DATA_WIDTH + 1;
	localparam int SQ_W       = 2 * DATA_WIDTH - 1;
	localparam int N2_W       = 2 * DATA_WIDTH;
	localparam int ANGLE_W    = 16;
	localparam int ANGLE_MAX  = 51472;

	// square roots: radicand widths (even), root is half of it
	localparam int ANG_RAD_W   = 60;
	localparam int ANG_SHIFT   = 28;
	localparam int NRM_RAD_W   = 62;
	localparam int NRM_SHIFT   = 30;
	localparam int ANG_ROOT_W  = ANG_RAD_W / 2;
	localparam int NRM_ROOT_W  = NRM_RAD_W / 2;

	// CORDIC
	localparam int CORDIC_STEPS = 20;
	localparam int CORDIC_W     = 33;
	localparam int X0_SHIFT     = 14;
	localparam int ZW           = 24;
	localparam int ACOS_W       = 23;
	localparam int PI_Q20       = 3294199;
	localparam int HALF_PI_Q20  = 1647099;
	localparam int ROUND_SHIFT  = 6;

	// axis division
	localparam int DIV_QW    = 17;
	localparam int DIV_NW    = 48;
	localparam int DIV_DW    = 32;
	localparam int NUM_SHIFT = 31;
	localparam int AXIS_POS_MAX = 32767;
	localparam int AXIS_NEG_MAX = 32768;

	// stage plan
	localparam int LAST_STAGE = 52;

	// atan(2^-i) in Q.20 radians
	function automatic logic [ZW-1:0] atan_q20(input int i);
		logic [ZW-1:0] v;
		case (i)
			0:       v = ZW'(823550);
			1:       v = ZW'(486170);
			2:       v = ZW'(256879);
			3:       v = ZW'(130396);
			4:       v = ZW'(65451);
			5:       v = ZW'(32757);
			6:       v = ZW'(16383);
			default: v = ZW'(32'd1 << (20 - i));
		endcase
		return v;
	endfunction
endpackage
`default_nettype wire

/* sv/qta_quat_if.sv */
// Request channel carrying one quaternion in signed Q1.15.
// Depends on qta_pkg.
`default_nettype none
interface qta_quat_if;
	import qta_pkg::*;
	logic                         valid;
	logic                         ready;
	logic signed [DATA_WIDTH-1:0] quat_w;
	logic signed [DATA_WIDTH-1:0] quat_x;
	logic signed [DATA_WIDTH-1:0] quat_y;
	logic signed [DATA_WIDTH-1:0] quat_z;
	modport source(output valid, quat_w, quat_x, quat_y, quat_z, input ready);
	modport sink(input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface
`default_nettype wire

/* sv/qta_axis_if.sv */
// Result channel carrying rotation angle and unit axis.
// Depends on qta_pkg.
`default_nettype none
interface qta_axis_if;
	import qta_pkg::*;
	logic                         valid;
	logic                         ready;
	logic [ANGLE_W-1:0]           rot_angle;
	logic signed [DATA_WIDTH-1:0] axis_x;
	logic signed [DATA_WIDTH-1:0] axis_y;
	logic signed [DATA_WIDTH-1:0] axis_z;
	logic                         no_axis;
	modport source(output valid, rot_angle, axis_x, axis_y, axis_z, no_axis, input ready);
	modport sink(input valid, rot_angle, axis_x, axis_y, axis_z, no_axis, output ready);
endinterface
`default_nettype wire

/* sv/quaternion_to_axis_angle.sv */
// Quaternion to axis-angle converter, top level.
// Depends on qta_pkg, qta_quat_if, qta_axis_if, qta_delay, qta_sqrt, qta_cordic,
// qta_div and quaternion_to_axis_angle_defines.svh.
//
// Usage:
//   quat carries one quaternion (w, x, y, z) in signed Q1.15 per request.
//   axis returns rot_angle = 2*acos(w) in unsigned Q3.13 radians and the unit
//   axis in signed Q1.15; no_axis is set with a zero axis when x = y = z = 0.
//   Throughput is one request per cycle while the output is taken: every
//   stage is a register and items follow back to back.
//   The depth is set by the two square roots (30 and 31 bit stages), the 20-step
//   CORDIC for the angle and the 17-stage axis divider.
//   Reset clears the valid bits only; the pipeline is empty afterwards.
//   While the result at the output is not taken, the whole pipeline holds and
//   quat.ready is low; bubbles inside the pipeline stay where they are.
//   Nothing is dropped or repeated across a stall.
`default_nettype none
`include "quaternion_to_axis_angle_defines.svh"
module quaternion_to_axis_angle (
	input  logic clk,
	input  logic arst_n,
	qta_quat_if.sink   quat,
	qta_axis_if.source axis
);
	import qta_pkg::*;

	logic                  en;
	logic [LAST_STAGE:1]   vld_s;

	// stage 1
	logic [AW_W-1:0]       aw_c;
	logic [AW_W-1:0]       mx_c, my_c, mz_c;
	logic [AW_W-1:0]       aw_s1;
	logic [SQ_W-1:0]       sqw_s1;
	logic [AW_W-1:0]       mx_s1, my_s1, mz_s1;
	logic [SQ_W-1:0]       sqx_s1, sqy_s1, sqz_s1;
	logic [4:0]            flags_s1;
	// stage 2
	logic [N2_W-1:0]       n2_s2;
	// angle path
	logic [SQ_W-1:0]       rem_a;
	logic [ANG_ROOT_W-1:0] ang_root;
	logic [AW_W-1:0]       aw_s31;
	logic signed [CORDIC_W-1:0] cx0, cy0;
	logic signed [ZW-1:0]  theta_s51;
	logic [ACOS_W-1:0]     theta_c, acos_c, round_c;
	// axis path
	logic [NRM_ROOT_W-1:0] nrm_root;
	logic [3*AW_W-1:0]     mag_s33;
	logic [DIV_NW-1:0]     num_x, num_y, num_z;
	logic [DIV_DW-1:0]     den_c;
	logic [DIV_QW-1:0]     qx_s50, qy_s50, qz_s50;
	logic [3*DIV_QW-1:0]   q_s51;
	logic [4:0]            flags_s51;
	logic [DATA_WIDTH-1:0] ax_c, ay_c, az_c;
	// output
	logic [ANGLE_W-1:0]    rot_angle_s52;
	logic [DATA_WIDTH-1:0] axis_x_s52, axis_y_s52, axis_z_s52;
	logic                  no_axis_s52;

	function automatic logic [AW_W-1:0] mag_of(input logic [DATA_WIDTH-1:0] v);
		logic [AW_W-1:0] e;
		e = {v[DATA_WIDTH-1], v};
		return v[DATA_WIDTH-1] ? AW_W'(-e) : e;
	endfunction

	function automatic logic [DATA_WIDTH-1:0] sat_axis(input logic [DIV_QW-1:0] q,
		input logic neg);
		logic [DIV_QW-1:0] m;
		logic [DIV_QW-1:0] n;
		if (neg) begin
			m = (q > DIV_QW'(AXIS_NEG_MAX)) ? DIV_QW'(AXIS_NEG_MAX) : q;
			n = -m;
		end else begin
			n = (q > DIV_QW'(AXIS_POS_MAX)) ? DIV_QW'(AXIS_POS_MAX) : q;
		end
		return n[DATA_WIDTH-1:0];
	endfunction

	// advance whenever the output slot is free or being taken
	assign en         = !vld_s[LAST_STAGE] || axis.ready;
	assign quat.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[LAST_STAGE-1:1], quat.valid};
		end
	end

	// stage 1: magnitudes and squares
	assign aw_c = mag_of(quat.quat_w);
	assign mx_c = mag_of(quat.quat_x);
	assign my_c = mag_of(quat.quat_y);
	assign mz_c = mag_of(quat.quat_z);

	always_ff @(posedge clk) begin
		if (en) begin
			aw_s1    <= aw_c;
			sqw_s1   <= SQ_W'(aw_c) * SQ_W'(aw_c);
			mx_s1    <= mx_c;
			my_s1    <= my_c;
			mz_s1    <= mz_c;
			sqx_s1   <= SQ_W'(mx_c) * SQ_W'(mx_c);
			sqy_s1   <= SQ_W'(my_c) * SQ_W'(my_c);
			sqz_s1   <= SQ_W'(mz_c) * SQ_W'(mz_c);
			flags_s1 <= {quat.quat_w[DATA_WIDTH-1],
				(mx_c == '0) && (my_c == '0) && (mz_c == '0),
				quat.quat_x[DATA_WIDTH-1], quat.quat_y[DATA_WIDTH-1],
				quat.quat_z[DATA_WIDTH-1]};
		end
	end

	// stage 2: squared norm of the vector part
	always_ff @(posedge clk) begin
		if (en) begin
			n2_s2 <= N2_W'(sqx_s1) + N2_W'(sqy_s1) + N2_W'(sqz_s1);
		end
	end

	// angle: s = sqrt(1 - w^2) in Q1.29, stages 2..31
	assign rem_a = SQ_W'(32'd1 << 30) - sqw_s1;

	qta_sqrt #(.RAD_W(ANG_RAD_W)) u_ang_sqrt (
		.clk (clk),
		.en  (en),
		.rad (ANG_RAD_W'(rem_a) << ANG_SHIFT),
		.root(ang_root)
	);

	qta_delay #(.WIDTH(AW_W), .DEPTH(ANG_ROOT_W)) u_aw_dly (
		.clk(clk), .en(en), .d(aw_s1), .q(aw_s31)
	);

	// angle: atan2(s, |w|), stages 32..51
	assign cx0 = $signed(CORDIC_W'(aw_s31) << X0_SHIFT);
	assign cy0 = $signed(CORDIC_W'(ang_root));

	qta_cordic u_cordic (
		.clk  (clk),
		.en   (en),
		.x0   (cx0),
		.y0   (cy0),
		.theta(theta_s51)
	);

	// axis: norm in Q1.30, stages 3..33
	qta_sqrt #(.RAD_W(NRM_RAD_W)) u_nrm_sqrt (
		.clk (clk),
		.en  (en),
		.rad (NRM_RAD_W'(n2_s2) << NRM_SHIFT),
		.root(nrm_root)
	);

	qta_delay #(.WIDTH(3*AW_W), .DEPTH(NRM_ROOT_W + 1)) u_mag_dly (
		.clk(clk), .en(en), .d({mx_s1, my_s1, mz_s1}), .q(mag_s33)
	);

	// axis: rounded quotients, stages 34..50
	assign den_c = {nrm_root, 1'b0};
	assign num_x = (DIV_NW'(mag_s33[3*AW_W-1:2*AW_W]) << NUM_SHIFT) + DIV_NW'(nrm_root);
	assign num_y = (DIV_NW'(mag_s33[2*AW_W-1:AW_W]) << NUM_SHIFT) + DIV_NW'(nrm_root);
	assign num_z = (DIV_NW'(mag_s33[AW_W-1:0]) << NUM_SHIFT) + DIV_NW'(nrm_root);

	qta_div u_div_x (.clk(clk), .en(en), .num(num_x), .den(den_c), .quo(qx_s50));
	qta_div u_div_y (.clk(clk), .en(en), .num(num_y), .den(den_c), .quo(qy_s50));
	qta_div u_div_z (.clk(clk), .en(en), .num(num_z), .den(den_c), .quo(qz_s50));

	// align quotients with the angle
	qta_delay #(.WIDTH(3*DIV_QW), .DEPTH(1)) u_q_dly (
		.clk(clk), .en(en), .d({qx_s50, qy_s50, qz_s50}), .q(q_s51)
	);

	qta_delay #(.WIDTH(5), .DEPTH(LAST_STAGE - 2)) u_flag_dly (
		.clk(clk), .en(en), .d(flags_s1), .q(flags_s51)
	);

	// clamp theta, fold for negative w, round to Q3.13
	always_comb begin
		if (theta_s51[ZW-1]) begin
			theta_c = '0;
		end else if (theta_s51 > ZW'(HALF_PI_Q20)) begin
			theta_c = ACOS_W'(HALF_PI_Q20);
		end else begin
			theta_c = ACOS_W'(theta_s51);
		end
		acos_c  = flags_s51[4] ? ACOS_W'(PI_Q20) - theta_c : theta_c;
		round_c = acos_c + ACOS_W'(32);
	end

	// saturate and sign the axis
	assign ax_c = sat_axis(q_s51[3*DIV_QW-1:2*DIV_QW], flags_s51[2]);
	assign ay_c = sat_axis(q_s51[2*DIV_QW-1:DIV_QW], flags_s51[1]);
	assign az_c = sat_axis(q_s51[DIV_QW-1:0], flags_s51[0]);

	// stage 52: output register
	always_ff @(posedge clk) begin
		if (en) begin
			rot_angle_s52 <= round_c[ROUND_SHIFT +: ANGLE_W];
			no_axis_s52   <= flags_s51[3];
			axis_x_s52    <= flags_s51[3] ? '0 : ax_c;
			axis_y_s52    <= flags_s51[3] ? '0 : ay_c;
			axis_z_s52    <= flags_s51[3] ? '0 : az_c;
		end
	end

	assign axis.valid     = vld_s[LAST_STAGE];
	assign axis.rot_angle = rot_angle_s52;
	assign axis.axis_x    = $signed(axis_x_s52);
	assign axis.axis_y    = $signed(axis_y_s52);
	assign axis.axis_z    = $signed(axis_z_s52);
	assign axis.no_axis   = no_axis_s52;

	// checks
	`QTA_ASSERT_NOW(a_no_axis_zero, !axis.valid || !axis.no_axis || (axis.axis_x == '0 && axis.axis_y == '0 && axis.axis_z == '0), "axis not zero with no_axis set")
	`QTA_ASSERT_NOW(a_angle_range, !axis.valid || axis.rot_angle <= ANGLE_W'(ANGLE_MAX), "rot_angle above two pi")
	`QTA_ASSERT_NEXT(a_stall_hold, !quat.ready, $stable(vld_s), "pipeline moved during stall")
	`QTA_ASSERT_NEXT(a_accept_enter, quat.valid && quat.ready, vld_s[1], "accepted request lost")
endmodule
`default_nettype wire

/* sv/qta_delay.sv */
// Enabled shift line that carries side data alongside the pipeline.
// Depends on nothing.
`default_nettype none
module qta_delay #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 1
) (
	input  logic             clk,
	input  logic             en,
	input  logic [WIDTH-1:0] d,
	output logic [WIDTH-1:0] q
);
	logic [WIDTH-1:0] tap_s [DEPTH];

	// advance all taps together
	always_ff @(posedge clk) begin
		if (en) begin
			tap_s[0] <= d;
			for (int i = 1; i < DEPTH; i++) begin
				tap_s[i] <= tap_s[i-1];
			end
		end
	end

	assign q = tap_s[DEPTH-1];
endmodule
`default_nettype wire

/* sv/qta_sqrt.sv */
// Pipelined floor square root, one root bit per stage.
// Depends on nothing; stages advance only while en is high.
`default_nettype none
module qta_sqrt #(
	parameter int RAD_W = 60
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic [RAD_W-1:0]     rad,
	output logic [RAD_W/2-1:0]   root
);
	localparam int ROOT_W = RAD_W / 2;

	logic [RAD_W-1:0] rem_s  [1:ROOT_W];
	logic [RAD_W-1:0] root_s [1:ROOT_W];

	for (genvar g = 0; g < ROOT_W; g++) begin : g_step
		localparam logic [RAD_W:0] BIT = (RAD_W+1)'(1) << (RAD_W - 2 - 2*g);
		logic [RAD_W-1:0] rem_in;
		logic [RAD_W-1:0] root_in;
		logic [RAD_W:0]   trial;
		logic             take;

		if (g == 0) begin : g_first
			assign rem_in  = rad;
			assign root_in = '0;
		end else begin : g_next
			assign rem_in  = rem_s[g];
			assign root_in = root_s[g];
		end

		assign trial = {1'b0, root_in} + BIT;
		assign take  = {1'b0, rem_in} >= trial;

		// settle one root bit
		always_ff @(posedge clk) begin
			if (en) begin
				if (take) begin
					rem_s[g+1]  <= rem_in - trial[RAD_W-1:0];
					root_s[g+1] <= (root_in >> 1) + BIT[RAD_W-1:0];
				end else begin
					rem_s[g+1]  <= rem_in;
					root_s[g+1] <= root_in >> 1;
				end
			end
		end
	end

	assign root = root_s[ROOT_W][ROOT_W-1:0];
endmodule
`default_nettype wire

/* sv/qta_cordic.sv */
// Pipelined CORDIC in vectoring mode, one rotation per stage.
// Depends on qta_pkg; stages advance only while en is high.
`default_nettype none
module qta_cordic (
	input  logic                                 clk,
	input  logic                                 en,
	input  logic signed [qta_pkg::CORDIC_W-1:0]  x0,
	input  logic signed [qta_pkg::CORDIC_W-1:0]  y0,
	output logic signed [qta_pkg::ZW-1:0]        theta
);
	import qta_pkg::*;

	logic signed [CORDIC_W-1:0] x_s [1:CORDIC_STEPS];
	logic signed [CORDIC_W-1:0] y_s [1:CORDIC_STEPS];
	logic signed [ZW-1:0]       z_s [1:CORDIC_STEPS];

	for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_rot
		localparam logic [ZW-1:0] ATAN = atan_q20(g);
		logic signed [CORDIC_W-1:0] x_in;
		logic signed [CORDIC_W-1:0] y_in;
		logic signed [ZW-1:0]       z_in;

		if (g == 0) begin : g_first
			assign x_in = x0;
			assign y_in = y0;
			assign z_in = '0;
		end else begin : g_next
			assign x_in = x_s[g];
			assign y_in = y_s[g];
			assign z_in = z_s[g];
		end

		// rotate toward the x axis
		always_ff @(posedge clk) begin
			if (en) begin
				if (!y_in[CORDIC_W-1]) begin
					x_s[g+1] <= x_in + (y_in >>> g);
					y_s[g+1] <= y_in - (x_in >>> g);
					z_s[g+1] <= z_in + $signed(ATAN);
				end else begin
					x_s[g+1] <= x_in - (y_in >>> g);
					y_s[g+1] <= y_in + (x_in >>> g);
					z_s[g+1] <= z_in - $signed(ATAN);
				end
			end
		end
	end

	assign theta = z_s[CORDIC_STEPS];
endmodule
`default_nettype wire

/* sv/qta_div.sv */
// Pipelined restoring divider, one quotient bit per stage.
// Depends on qta_pkg; stages advance only while en is high.
`default_nettype none
module qta_div (
	input  logic                          clk,
	input  logic                          en,
	input  logic [qta_pkg::DIV_NW-1:0]    num,
	input  logic [qta_pkg::DIV_DW-1:0]    den,
	output logic [qta_pkg::DIV_QW-1:0]    quo
);
	import qta_pkg::*;

	logic [DIV_NW-1:0] rem_s [1:DIV_QW];
	logic [DIV_DW-1:0] den_s [1:DIV_QW];
	logic [DIV_QW-1:0] quo_s [1:DIV_QW];

	for (genvar g = 0; g < DIV_QW; g++) begin : g_bit
		localparam int K = DIV_QW - 1 - g;
		logic [DIV_NW-1:0] rem_in;
		logic [DIV_DW-1:0] den_in;
		logic [DIV_QW-1:0] quo_in;
		logic [DIV_NW-1:0] sub;
		logic              take;

		if (g == 0) begin : g_first
			assign rem_in = num;
			assign den_in = den;
			assign quo_in = '0;
		end else begin : g_next
			assign rem_in = rem_s[g];
			assign den_in = den_s[g];
			assign quo_in = quo_s[g];
		end

		assign sub  = DIV_NW'(den_in) << K;
		assign take = rem_in >= sub;

		// subtract the shifted divisor when it fits
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[g+1] <= take ? rem_in - sub : rem_in;
				den_s[g+1] <= den_in;
				quo_s[g+1] <= {quo_in[DIV_QW-2:0], take};
			end
		end
	end

	assign quo = quo_s[DIV_QW];
endmodule
`default_nettype wire

/* verif/quaternion_to_axis_angle_tb.sv */
// Testbench for the quaternion to axis-angle converter: a directed table, then random requests,
// each result checked in order against a bit-exact model. Depends on qta_pkg, both interfaces and the converter.
`default_nettype none
module quaternion_to_axis_angle_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import qta_pkg::*;

	typedef struct packed {
		logic [15:0] w, x, y, z;
	} quat_t;

	typedef struct packed {
		logic [15:0] angle;
		logic [15:0] ax, ay, az;
		logic        none;
	} pose_t;

	typedef struct {
		quat_t q;
		bit    known;
		pose_t p;
	} row_t;

	localparam int N_RANDOM = 1300;
	localparam int PIPE_LAT = 52;
	localparam longint CYCLE_LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	longint cycles = 0;
	int errors = 0;
	int send_idle = 0;
	int recv_stall = 0;
	bit hold_off = 1'b0;

	qta_quat_if quat ();
	qta_axis_if axis ();

	quaternion_to_axis_angle dut (.clk(clk), .arst_n(arst_n), .quat(quat), .axis(axis));

	pose_t poses_due[$];
	quat_t quats_todo[$];
	row_t  rows[$];

	// integer square root, bit by bit
	function automatic longint unsigned root_of(input longint unsigned n);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint sra(input longint v, input int s);
		return v >>> s;
	endfunction

	function automatic logic [15:0] angle_q13(input logic signed [15:0] w);
		longint unsigned aw, rem;
		longint xv, yv, zz, dx, dy, th, ac;
		longint tbl[20];
		tbl = '{823550, 486170, 256879, 130396, 65451, 32757, 16383, 8192,
			4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2};
		aw = (w < 0) ? -longint'(w) : longint'(w);
		rem = (64'd1 << 30) - aw * aw;
		xv = aw << 14;
		yv = root_of(rem << 28);
		zz = 0;
		for (int i = 0; i < 20; i++) begin
			dx = sra(yv, i);
			dy = sra(xv, i);
			if (yv >= 0) begin
				xv += dx; yv -= dy; zz += tbl[i];
			end else begin
				xv -= dx; yv += dy; zz -= tbl[i];
			end
		end
		th = zz < 0 ? 0 : (zz > HALF_PI_Q20 ? HALF_PI_Q20 : zz);
		ac = (w < 0) ? PI_Q20 - th : th;
		return 16'((ac + 32) >> 6);
	endfunction

	function automatic logic [15:0] unit_part(input logic signed [15:0] v,
			input longint unsigned nr);
		longint unsigned mag, q;
		mag = (v < 0) ? -longint'(v) : longint'(v);
		q = ((mag << 31) + nr) / (2 * nr);
		if (v < 0) begin
			if (q > AXIS_NEG_MAX) q = AXIS_NEG_MAX;
			return 16'(-q);
		end
		if (q > AXIS_POS_MAX) q = AXIS_POS_MAX;
		return 16'(q);
	endfunction

	function automatic pose_t convert(input quat_t q);
		pose_t p;
		longint x, y, z;
		longint unsigned n2, nr;
		x = signed'(q.x);
		y = signed'(q.y);
		z = signed'(q.z);
		n2 = x * x + y * y + z * z;
		p.angle = angle_q13(q.w);
		if (n2 == 0) begin
			p.ax = 0; p.ay = 0; p.az = 0; p.none = 1'b1;
		end else begin
			nr = root_of(n2 << 30);
			p.ax = unit_part(q.x, nr);
			p.ay = unit_part(q.y, nr);
			p.az = unit_part(q.z, nr);
			p.none = 1'b0;
		end
		return p;
	endfunction

	function automatic logic [15:0] rand_part(input int mode);
		case (mode)
			0: return 16'($urandom);
			1: return 16'($urandom_range(0, 15)) - 16'd8;
			2: return $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
			default: return 16'($urandom_range(0, 65535) >>> $urandom_range(0, 15));
		endcase
	endfunction

	task automatic add_row(input logic [15:0] w, x, y, z, input bit known, input pose_t p);
		row_t r;
		r.q = '{w, x, y, z};
		r.known = known;
		r.p = p;
		rows.push_back(r);
	endtask

	initial begin
		forever #4 clk = ~clk;
	end

	// count cycles, stop a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// drive requests
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quat.valid <= 1'b0;
			quat.quat_w <= '0;
			quat.quat_x <= '0;
			quat.quat_y <= '0;
			quat.quat_z <= '0;
		end else begin
			automatic bit taken = quat.valid && quat.ready;
			if (taken) poses_due.push_back(convert({quat.quat_w, quat.quat_x,
				quat.quat_y, quat.quat_z}));
			if (!quat.valid || taken) begin
				if (quats_todo.size() != 0 && !hold_off && $urandom_range(0, 99) >= send_idle)
						begin
					automatic quat_t q = quats_todo.pop_front();
					quat.valid <= 1'b1;
					quat.quat_w <= q.w;
					quat.quat_x <= q.x;
					quat.quat_y <= q.y;
					quat.quat_z <= q.z;
				end else begin
					quat.valid <= 1'b0;
				end
			end
		end
	end

	// take and check results
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis.ready <= 1'b0;
		end else begin
			if (axis.valid && axis.ready) begin
				if (poses_due.size() == 0) begin
					$error("result with no request outstanding");
					errors++;
				end else begin
					automatic pose_t e = poses_due.pop_front();
					if (axis.rot_angle !== e.angle) begin
						$error("rot_angle expected %0d got %0d", e.angle, axis.rot_angle);
						errors++;
					end
					if (axis.axis_x !== e.ax) begin
						$error("axis_x expected %0d got %0d", $signed(e.ax), axis.axis_x);
						errors++;
					end
					if (axis.axis_y !== e.ay) begin
						$error("axis_y expected %0d got %0d", $signed(e.ay), axis.axis_y);
						errors++;
					end
					if (axis.axis_z !== e.az) begin
						$error("axis_z expected %0d got %0d", $signed(e.az), axis.axis_z);
						errors++;
					end
					if (axis.no_axis !== e.none) begin
						$error("no_axis expected %0d got %0d", e.none, axis.no_axis);
						errors++;
					end
				end
			end
			axis.ready <= ($urandom_range(0, 99) >= recv_stall);
		end
	end

	task automatic drain();
		while (quats_todo.size() != 0 || quat.valid || poses_due.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		row_t r;
		int mode;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// directed table: typed results where obvious, the rest from the model
		add_row(16'h7fff, 16'h0000, 16'h0000, 16'h0000, 1, '{16'd128, 0, 0, 0, 1'b1});
		add_row(16'h8000, 16'h0000, 16'h0000, 16'h0000, 1, '{16'd51472, 0, 0, 0, 1'b1});
		add_row(16'h0000, 16'h7fff, 16'h0000, 16'h0000, 1, '{16'd25736, 16'h7fff, 0, 0, 1'b0});
		add_row(16'h0000, 16'h0000, 16'h8000, 16'h0000, 1, '{16'd25736, 0, 16'h8000, 0, 1'b0});
		add_row(16'h0000, 16'h0000, 16'h0000, 16'h0001, 1, '{16'd25736, 0, 0, 16'h7fff, 1'b0});
		add_row(16'h0000, 16'h0000, 16'h0000, 16'hffff, 1, '{16'd25736, 0, 0, 16'h8000, 1'b0});
		add_row(16'h0000, 16'h0000, 16'h0000, 16'h0000, 0, '0);
		add_row(16'h5a82, 16'h5a82, 16'h0000, 16'h0000, 0, '0);
		add_row(16'hffff, 16'h8000, 16'h8000, 16'h8000, 0, '0);
		add_row(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 0, '0);
		add_row(16'h8001, 16'h0001, 16'hffff, 16'h0001, 0, '0);
		add_row(16'h0001, 16'h4000, 16'h4000, 16'h4000, 0, '0);
		add_row(16'h4000, 16'h1234, 16'hedcb, 16'h0100, 0, '0);
		add_row(16'hc000, 16'h0000, 16'h0003, 16'h0004, 0, '0);
		foreach (rows[i]) begin
			r = rows[i];
			if (r.known && convert(r.q) !== r.p) begin
				$error("table row %0d disagrees with model", i);
				errors++;
			end
			quats_todo.push_back(r.q);
		end
		drain();

		// random phases with different idling
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: begin send_idle = 0;  recv_stall = 0;  end
				1: begin send_idle = 46; recv_stall = 0;  end
				2: begin send_idle = 0;  recv_stall = 46; end
				3: begin send_idle = 13; recv_stall = 13; end
				default: begin send_idle = 0; recv_stall = 0; end
			endcase
			for (int k = 0; k < N_RANDOM / 5; k++) begin
				mode = $urandom_range(0, 3);
				quats_todo.push_back('{rand_part($urandom_range(0, 3)), rand_part(mode),
					rand_part(mode), rand_part(mode)});
				if (k == 100 && ph == 3) begin
					// pause the sender until the pipe is empty
					while (quats_todo.size() != 0 || quat.valid) @(posedge clk);
					hold_off = 1'b1;
					while (poses_due.size() != 0) @(posedge clk);
					hold_off = 1'b0;
				end
			end
			drain();
		end

		repeat (PIPE_LAT + 10) @(posedge clk);
		if (errors == 0 && poses_due.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end
endmodule
`default_nettype wire

/* files.f */
+incdir+sv
sv/qta_pkg.sv
sv/qta_quat_if.sv
sv/qta_axis_if.sv
sv/qta_delay.sv
sv/qta_sqrt.sv
sv/qta_cordic.sv
sv/qta_div.sv
sv/quaternion_to_axis_angle.sv
verif/quaternion_to_axis_angle_tb.sv
